[rtl/vdd_pkg.sv]
// Package for the vector distance / direction block: widths and latencies.
// Used by every module of the block; depends on nothing.
`default_nettype none

package vdd_pkg;

    localparam int COORD_W    = 24;             // input coordinate width, Q16.8
    localparam int FRAC_BITS  = 8;              // coordinate fraction bits
    localparam int DIR_FRAC   = 14;             // direction fraction bits, Q2.14
    localparam int DIST_W     = 25;             // distance port width
    localparam int DIR_W      = 16;             // direction port width

    localparam int MAG_W      = COORD_W + 1;    // difference magnitude
    localparam int SQ_W       = 2 * MAG_W;      // one square
    localparam int SUM_W      = SQ_W + 1;       // sum of two squares
    localparam int ROOT_W     = MAG_W;          // floor root of the sum
    localparam int DEN_W      = ROOT_W + 1;     // root plus one LSB
    localparam int QUO_W      = DIR_FRAC;       // quotient magnitude below 1.0
    localparam int DIVD_W     = MAG_W + DIR_FRAC;

    // diff, square, sum, root bits, divisor, quotient bits, output
    localparam int LATENCY    = 3 + ROOT_W + 1 + QUO_W + 1;

    localparam logic MODE_DIST = 1'b0;
    localparam logic MODE_DIR  = 1'b1;

endpackage

`default_nettype wire

[rtl/vdd_sqrt.sv]
// Pipelined floor square root, one root bit per register stage.
// Depends on vdd_pkg for the radicand and root widths.
`default_nettype none

module vdd_sqrt
    import vdd_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              en,
    input  wire logic [SUM_W-1:0]  radicand,
    output logic      [ROOT_W-1:0] root
);

    logic [SUM_W-1:0]  rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        localparam int BIT = ROOT_W - 1 - k;
        logic [SUM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [SUM_W-1:0]  trial;
        logic [SUM_W-1:0]  rem_next;
        logic [ROOT_W-1:0] root_next;

        if (k == 0) begin : g_first
            assign rem_in  = radicand;
            assign root_in = '0;
        end else begin : g_rest
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
        end

        // (r + 2^i)^2 - r^2 = r*2^(i+1) + 2^(2i); the two terms never overlap
        assign trial = (SUM_W'(root_in) << (BIT + 1)) | (SUM_W'(1) << (2 * BIT));

        // keep the bit when the remainder covers the trial
        always_comb begin
            if (rem_in >= trial) begin
                rem_next  = rem_in - trial;
                root_next = root_in | (ROOT_W'(1) << BIT);
            end else begin
                rem_next  = rem_in;
                root_next = root_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
            end
        end
    end

    assign root = root_reg[ROOT_W-1];

endmodule

`default_nettype wire

[rtl/vdd_div.sv]
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on vdd_pkg; the quotient is known to stay below 2^QUO_W.
`default_nettype none

module vdd_div
    import vdd_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              en,
    input  wire logic [DIVD_W-1:0] dividend,
    input  wire logic [DEN_W-1:0]  divisor,
    output logic      [QUO_W-1:0]  quotient
);

    localparam int CMP_W = DEN_W + QUO_W;

    logic [DIVD_W-1:0] rem_reg [QUO_W];
    logic [DEN_W-1:0]  den_reg [QUO_W];
    logic [QUO_W-1:0]  quo_reg [QUO_W];

    for (genvar k = 0; k < QUO_W; k++) begin : g_stage
        localparam int BIT = QUO_W - 1 - k;
        logic [DIVD_W-1:0] rem_in;
        logic [DEN_W-1:0]  den_in;
        logic [QUO_W-1:0]  quo_in;
        logic [CMP_W-1:0]  shifted;
        logic [DIVD_W-1:0] rem_next;
        logic [QUO_W-1:0]  quo_next;

        if (k == 0) begin : g_first
            assign rem_in = dividend;
            assign den_in = divisor;
            assign quo_in = '0;
        end else begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign den_in = den_reg[k-1];
            assign quo_in = quo_reg[k-1];
        end

        assign shifted = CMP_W'(den_in) << BIT;

        // subtract the shifted divisor when it fits
        always_comb begin
            if (CMP_W'(rem_in) >= shifted) begin
                rem_next = DIVD_W'(CMP_W'(rem_in) - shifted);
                quo_next = quo_in | (QUO_W'(1) << BIT);
            end else begin
                rem_next = rem_in;
                quo_next = quo_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= rem_next;
                den_reg[k] <= den_in;
                quo_reg[k] <= quo_next;
            end
        end
    end

    assign quotient = quo_reg[QUO_W-1];

endmodule

`default_nettype wire

[rtl/vector_distance_direction.sv]
// Channel   Ports                              Direction  Carries
// request   s_valid s_ready s_mode s_ax..s_by  in         mode and two points
// result    m_valid m_ready m_distance m_dir_* out        distance or unit vector
//
// One request per cycle unless a result stalls; most of the pipeline's length comes from
// the root pipeline (one bit per stage) and the divider (one bit per stage).
// aresetn is synchronous, active low, and clears only the valid bits.
// A stalled result freezes the whole pipeline; a bubble at the output never blocks input.
// Depends on vdd_pkg, vdd_sqrt and vdd_div.
`default_nettype none

module vector_distance_direction
    import vdd_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic                     s_mode,
    input  wire logic signed [COORD_W-1:0] s_ax,
    input  wire logic signed [COORD_W-1:0] s_ay,
    input  wire logic signed [COORD_W-1:0] s_bx,
    input  wire logic signed [COORD_W-1:0] s_by,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic        [DIST_W-1:0]      m_distance,
    output logic signed [DIR_W-1:0]       m_dir_x,
    output logic signed [DIR_W-1:0]       m_dir_y
);

    logic en;
    logic [LATENCY-1:0] vld_reg;

    assign en      = ~vld_reg[LATENCY-1] | m_ready;
    assign s_ready = en;
    assign m_valid = vld_reg[LATENCY-1];

    // advance the valid bits with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LATENCY-2:0], s_valid};
        end
    end

    // stage 1: differences and magnitudes
    logic signed [MAG_W-1:0] dx, dy;
    logic [MAG_W-1:0] mx_reg, my_reg;
    logic sx_reg, sy_reg, mode_reg;

    assign dx = MAG_W'(s_bx) - MAG_W'(s_ax);
    assign dy = MAG_W'(s_by) - MAG_W'(s_ay);

    always_ff @(posedge aclk) begin
        if (en) begin
            mx_reg   <= dx[MAG_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
            my_reg   <= dy[MAG_W-1] ? MAG_W'(-dy) : MAG_W'(dy);
            sx_reg   <= dx[MAG_W-1];
            sy_reg   <= dy[MAG_W-1];
            mode_reg <= s_mode;
        end
    end

    // stage 2: squares
    logic [SQ_W-1:0] sqx_reg, sqy_reg;
    logic [MAG_W-1:0] mx2_reg, my2_reg;
    logic sx2_reg, sy2_reg, mode2_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            sqx_reg   <= SQ_W'(mx_reg) * SQ_W'(mx_reg);
            sqy_reg   <= SQ_W'(my_reg) * SQ_W'(my_reg);
            mx2_reg   <= mx_reg;
            my2_reg   <= my_reg;
            sx2_reg   <= sx_reg;
            sy2_reg   <= sy_reg;
            mode2_reg <= mode_reg;
        end
    end

    // stage 3: sum of squares
    logic [SUM_W-1:0] sum_reg;
    logic [MAG_W-1:0] mx3_reg, my3_reg;
    logic sx3_reg, sy3_reg, mode3_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            sum_reg   <= SUM_W'(sqx_reg) + SUM_W'(sqy_reg);
            mx3_reg   <= mx2_reg;
            my3_reg   <= my2_reg;
            sx3_reg   <= sx2_reg;
            sy3_reg   <= sy2_reg;
            mode3_reg <= mode2_reg;
        end
    end

    // root stages, with the side data delayed alongside
    logic [ROOT_W-1:0] root;
    logic [MAG_W-1:0]  rmx_reg  [ROOT_W];
    logic [MAG_W-1:0]  rmy_reg  [ROOT_W];
    logic [ROOT_W-1:0] rsx_reg, rsy_reg, rmode_reg;

    vdd_sqrt u_sqrt (
        .aclk     (aclk),
        .en       (en),
        .radicand (sum_reg),
        .root     (root)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            rmx_reg[0] <= mx3_reg;
            rmy_reg[0] <= my3_reg;
            for (int i = 1; i < ROOT_W; i++) begin
                rmx_reg[i] <= rmx_reg[i-1];
                rmy_reg[i] <= rmy_reg[i-1];
            end
            rsx_reg   <= {rsx_reg[ROOT_W-2:0], sx3_reg};
            rsy_reg   <= {rsy_reg[ROOT_W-2:0], sy3_reg};
            rmode_reg <= {rmode_reg[ROOT_W-2:0], mode3_reg};
        end
    end

    // divisor stage: root plus one LSB, scaled dividends
    logic [DEN_W-1:0]  den_reg;
    logic [DIVD_W-1:0] nx_reg, ny_reg;
    logic [ROOT_W-1:0] len_reg;
    logic sx4_reg, sy4_reg, mode4_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            den_reg   <= DEN_W'(root) + DEN_W'(1);
            nx_reg    <= DIVD_W'(rmx_reg[ROOT_W-1]) << DIR_FRAC;
            ny_reg    <= DIVD_W'(rmy_reg[ROOT_W-1]) << DIR_FRAC;
            len_reg   <= root;
            sx4_reg   <= rsx_reg[ROOT_W-1];
            sy4_reg   <= rsy_reg[ROOT_W-1];
            mode4_reg <= rmode_reg[ROOT_W-1];
        end
    end

    // divider stages for both components
    logic [QUO_W-1:0]  qx, qy;
    logic [ROOT_W-1:0] dlen_reg [QUO_W];
    logic [QUO_W-1:0]  dsx_reg, dsy_reg, dmode_reg;

    vdd_div u_div_x (
        .aclk     (aclk),
        .en       (en),
        .dividend (nx_reg),
        .divisor  (den_reg),
        .quotient (qx)
    );

    vdd_div u_div_y (
        .aclk     (aclk),
        .en       (en),
        .dividend (ny_reg),
        .divisor  (den_reg),
        .quotient (qy)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            dlen_reg[0] <= len_reg;
            for (int i = 1; i < QUO_W; i++) begin
                dlen_reg[i] <= dlen_reg[i-1];
            end
            dsx_reg   <= {dsx_reg[QUO_W-2:0], sx4_reg};
            dsy_reg   <= {dsy_reg[QUO_W-2:0], sy4_reg};
            dmode_reg <= {dmode_reg[QUO_W-2:0], mode4_reg};
        end
    end

    // output stage: apply signs, zero the unused fields
    logic [DIR_W-1:0] ux, uy;
    logic [DIST_W-1:0] dist_reg;
    logic [DIR_W-1:0]  dirx_reg, diry_reg;

    assign ux = DIR_W'(qx);
    assign uy = DIR_W'(qy);

    always_ff @(posedge aclk) begin
        if (en) begin
            if (dmode_reg[QUO_W-1] == MODE_DIR) begin
                dist_reg <= '0;
                dirx_reg <= dsx_reg[QUO_W-1] ? -ux : ux;
                diry_reg <= dsy_reg[QUO_W-1] ? -uy : uy;
            end else begin
                dist_reg <= DIST_W'(dlen_reg[QUO_W-1]);
                dirx_reg <= '0;
                diry_reg <= '0;
            end
        end
    end

    assign m_distance = dist_reg;
    assign m_dir_x    = dirx_reg;
    assign m_dir_y    = diry_reg;

endmodule

`default_nettype wire

[rtl/vdd_checker.sv]
// Port-level checks for vector_distance_direction, bound to the top level.
// Depends on vdd_pkg for the port widths.
`default_nettype none

module vdd_checker
    import vdd_pkg::*;
(
    input wire logic                     aclk,
    input wire logic                     aresetn,
    input wire logic                     s_ready,
    input wire logic                     m_valid,
    input wire logic                     m_ready,
    input wire logic        [DIST_W-1:0] m_distance,
    input wire logic signed [DIR_W-1:0]  m_dir_x,
    input wire logic signed [DIR_W-1:0]  m_dir_y
);

    localparam logic signed [DIR_W-1:0] ONE = DIR_W'(1) << DIR_FRAC;

    // a reset leaves no result pending
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a stalled result holds its value
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_distance)
            && $stable(m_dir_x) && $stable(m_dir_y))
        else $error("stalled result changed");

    // requests are taken whenever the output is free or drains
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid || m_ready) |-> s_ready)
        else $error("request refused while output can move");

    // a distance result carries no direction
    a_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_distance != '0 |-> m_dir_x == '0 && m_dir_y == '0)
        else $error("distance and direction both set");

    // direction components stay within unit magnitude
    a_unit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_dir_x <= ONE && m_dir_x >= -ONE
            && m_dir_y <= ONE && m_dir_y >= -ONE)
        else $error("direction out of range");

endmodule

bind vector_distance_direction vdd_checker u_vdd_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_distance (m_distance),
    .m_dir_x    (m_dir_x),
    .m_dir_y    (m_dir_y)
);

`default_nettype wire

[verif/testbench.sv]
// Testbench for vector_distance_direction: drives point pairs in both modes and
// checks distance and unit direction against a bit-exact predictor.
// Depends on vdd_pkg and the block's RTL.
`timescale 1ns / 100ps

module testbench;
    import vdd_pkg::*;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    logic s_mode;
    logic signed [COORD_W-1:0] s_ax, s_ay, s_bx, s_by;
    logic m_valid;
    logic m_ready;
    logic [DIST_W-1:0] m_distance;
    logic signed [DIR_W-1:0] m_dir_x, m_dir_y;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic [DIR_W-1:0] dir_x;
        logic [DIR_W-1:0] dir_y;
    } vec_result_t;

    vec_result_t expected_results[$];
    int errors = 0;
    int requests_sent = 0;
    int results_seen = 0;
    int dir_requests = 0;
    longint cycle_count = 0;
    bit idle_enable = 1'b1;
    bit hold_results = 1'b0;

    vector_distance_direction dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_mode(s_mode),
        .s_ax(s_ax), .s_ay(s_ay), .s_bx(s_bx), .s_by(s_by),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_distance(m_distance), .m_dir_x(m_dir_x), .m_dir_y(m_dir_y)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Floor square root of a sum below 2^51, one bit at a time
    function automatic logic [ROOT_W-1:0] floor_root(input logic [SUM_W-1:0] n);
        logic [ROOT_W-1:0] root;
        logic [ROOT_W-1:0] trial;
        root = '0;
        for (int i = ROOT_W - 1; i >= 0; i--) begin
            trial = root | (ROOT_W'(1) << i);
            if ({{SUM_W{1'b0}}, trial} * {{SUM_W{1'b0}}, trial} <= {{SUM_W{1'b0}}, n})
                root = trial;
        end
        return root;
    endfunction

    // Signed quotient truncated toward zero, Q2.14
    function automatic logic [DIR_W-1:0] unit_component(input longint d, input longint den);
        longint mag;
        longint q;
        mag = (d < 0) ? -d : d;
        q = (mag << DIR_FRAC) / den;
        if (d < 0)
            q = -q;
        return q[DIR_W-1:0];
    endfunction

    function automatic vec_result_t predict_vector(input logic mode,
            input logic signed [COORD_W-1:0] ax, input logic signed [COORD_W-1:0] ay,
            input logic signed [COORD_W-1:0] bx, input logic signed [COORD_W-1:0] by);
        longint dx;
        longint dy;
        logic [ROOT_W-1:0] len;
        vec_result_t r;
        dx = longint'(bx) - longint'(ax);
        dy = longint'(by) - longint'(ay);
        len = floor_root(SUM_W'(dx * dx + dy * dy));
        r = '0;
        if (mode == MODE_DIST) begin
            r.distance = len[DIST_W-1:0];
        end else begin
            r.dir_x = unit_component(dx, longint'(len) + 1);
            r.dir_y = unit_component(dy, longint'(len) + 1);
        end
        return r;
    endfunction

    // Send one request, idling at random first; valid stays high between requests
    task automatic send_request(input logic mode, input logic signed [COORD_W-1:0] ax,
            input logic signed [COORD_W-1:0] ay, input logic signed [COORD_W-1:0] bx,
            input logic signed [COORD_W-1:0] by);
        if (idle_enable && $urandom_range(99) < 14) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_mode <= mode;
        s_ax <= ax;
        s_ay <= ay;
        s_bx <= bx;
        s_by <= by;
        expected_results.insert(expected_results.size(),
                                predict_vector(mode, ax, ay, bx, by));
        requests_sent++;
        if (mode == MODE_DIR)
            dir_requests++;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic end_requests();
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic signed [COORD_W-1:0] rand_coord();
        case ($urandom_range(3))
            0: return COORD_W'($urandom);
            1: return COORD_W'($signed($urandom_range(0, 2047)) - 1024);
            2: return ($urandom_range(1)) ? {1'b0, {(COORD_W-1){1'b1}}}
                                          : {1'b1, {(COORD_W-1){1'b0}}};
            default: return COORD_W'($signed($urandom_range(0, 131071)) - 65536);
        endcase
    endfunction

    // Extremes, equal points, axis-aligned and diagonal vectors in both modes
    task automatic test_directed();
        logic signed [COORD_W-1:0] cmax;
        logic signed [COORD_W-1:0] cmin;
        cmax = {1'b0, {(COORD_W-1){1'b1}}};
        cmin = {1'b1, {(COORD_W-1){1'b0}}};
        for (int m = 0; m < 2; m++) begin
            send_request(m[0], '0, '0, '0, '0);
            send_request(m[0], cmax, cmax, cmax, cmax);
            send_request(m[0], cmin, cmin, cmax, cmax);
            send_request(m[0], cmax, cmax, cmin, cmin);
            send_request(m[0], cmin, '0, cmax, '0);
            send_request(m[0], '0, cmax, '0, cmin);
            send_request(m[0], '0, '0, 24'sd256, 24'sd0);
            send_request(m[0], '0, '0, -24'sd1, 24'sd1);
            send_request(m[0], 24'sd768, 24'sd1024, -24'sd1, -24'sd1);
            send_request(m[0], cmin, cmax, cmax, cmin);
            send_request(m[0], '0, '0, 24'sd1, 24'sd0);
        end
        end_requests();
    endtask

    // Random pairs, with a stretch of no idling on either side
    task automatic test_random(input int count);
        for (int i = 0; i < count; i++) begin
            idle_enable = !(i >= count / 2 && i < count / 2 + 300);
            send_request(1'($urandom_range(1)), rand_coord(), rand_coord(),
                         rand_coord(), rand_coord());
        end
        idle_enable = 1'b1;
        end_requests();
    endtask

    // Hold the result side off long enough for the pipeline to fill and stall input
    task automatic test_backpressure();
        hold_results = 1'b1;
        for (int i = 0; i < 3 * LATENCY; i++)
            send_request(1'($urandom_range(1)), rand_coord(), rand_coord(),
                         rand_coord(), rand_coord());
        end_requests();
    endtask

    // Drop the result side during a hold-off counted in its own process
    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_results) begin
                m_ready <= 1'b0;
                repeat (4 * LATENCY) @(posedge aclk);
                hold_results = 1'b0;
            end
            m_ready <= !(idle_enable && $urandom_range(99) < 14);
        end
    end

    // Compare each result with the oldest prediction
    always @(posedge aclk) begin
        vec_result_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result dist=%0d dx=%0d dy=%0d", $time,
                         m_distance, m_dir_x, m_dir_y);
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (m_distance !== want.distance) begin
                    $display("%0t: distance expected %0d actual %0d", $time,
                             want.distance, m_distance);
                    errors++;
                end
                if (m_dir_x !== want.dir_x) begin
                    $display("%0t: dir_x expected %0d actual %0d", $time,
                             $signed(want.dir_x), m_dir_x);
                    errors++;
                end
                if (m_dir_y !== want.dir_y) begin
                    $display("%0t: dir_y expected %0d actual %0d", $time,
                             $signed(want.dir_y), m_dir_y);
                    errors++;
                end
            end
        end
    end

    // Abort on a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 200000) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("testbench failed");
            $finish;
        end
    end

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_mode = MODE_DIST;
        s_ax = '0;
        s_ay = '0;
        s_bx = '0;
        s_by = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_backpressure();
        test_random(2000);
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
        $display("Covered %0d requests (%0d direction), %0d results checked,",
                 requests_sent, dir_requests, results_seen);
        $display("including extremes, equal points and a full-pipeline stall.");
        if (errors == 0 && expected_results.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end
endmodule
